// File: rtl/spim_pkg.sv
// shared codes, widths and status bit positions for the spi master controller
package spim_pkg;

  localparam int MODE_W     = 2;
  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int BAUD_W     = 3;
  localparam int CNT_W      = 5;
  localparam int PRESC_W    = 8;

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [DATA_W-1:0] data_t;

  localparam mode_t MODE_TICK   = 2'd0;
  localparam mode_t MODE_STATUS = 2'd1;
  localparam mode_t MODE_READ   = 2'd2;
  localparam mode_t MODE_WRITE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BAUD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LSB    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd5;

  localparam int ST_RXNE_BIT = 0;
  localparam int ST_TXE_BIT  = 1;
  localparam int ST_OVR_BIT  = 6;
  localparam int ST_BSY_BIT  = 7;

endpackage

// File: rtl/spi_master_controller.sv
// spi master controller: bus access and tick decode, shifter, buffers, result register
//
// channel   direction  handshake               payload
// in        sink       in_valid / in_stall     mode, write_data, miso_in
// out       source     out_valid / out_stall   read_data, sck_out, mosi_out, status flags
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one beat per cycle while in_stall is low: each accepted beat updates all state and loads the result
// register in the same cycle, so the result appears in the cycle after acceptance
// in_stall rises only while the result register holds a beat that is stalled
// rst is synchronous and clears all state but the result register payload; sck rests at the configured polarity
// cfg_ready is always high; the user must write registers only while the block is idle, the block does not enforce it
module spi_master_controller (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  spim_pkg::mode_t                    mode,
  input  spim_pkg::data_t                    write_data,
  input  logic                               miso_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output spim_pkg::data_t                    read_data,
  output logic                               sck_out,
  output logic                               mosi_out,
  output logic                               tx_empty,
  output logic                               rx_full,
  output logic                               busy_res,
  output logic                               overrun,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spim_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spim_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import spim_pkg::*;

  // configuration
  logic [BAUD_W-1:0] baud_code;
  logic clock_polarity, clock_phase, lsb_first, wide_frame, enable;

  // state
  data_t tx_buffer, shift_reg, rx_buffer;
  logic tx_buffer_empty, rx_buffer_full, overrun_flag, overrun_data_read;
  logic [CNT_W-1:0] bit_count;
  logic [PRESC_W-1:0] prescale_count;
  logic sck_level, shifting, mosi_level;

  data_t tx_buffer_next, shift_reg_next, rx_buffer_next, rd_next;
  logic tx_buffer_empty_next, rx_buffer_full_next, overrun_flag_next, overrun_data_read_next;
  logic [CNT_W-1:0] bit_count_next;
  logic [PRESC_W-1:0] prescale_count_next;
  logic sck_level_next, shifting_next, mosi_level_next;

  logic in_accept;
  logic [CNT_W-1:0] frame_len;
  data_t frame_mask;
  logic [PRESC_W-1:0] prescale_inc;
  logic [PRESC_W:0] baud_limit;
  logic leading;

  function automatic logic out_bit(input data_t s, input logic lsb, input logic wide);
    logic b;
    if (lsb) begin
      b = s[0];
    end else if (wide) begin
      b = s[15];
    end else begin
      b = s[7];
    end
    return b;
  endfunction

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign frame_len    = wide_frame ? CNT_W'(16) : CNT_W'(8);
  assign frame_mask   = wide_frame ? 16'hffff : 16'h00ff;
  assign prescale_inc = prescale_count + PRESC_W'(1);
  assign baud_limit   = (PRESC_W+1)'(1) << baud_code;

  always_comb begin
    tx_buffer_next         = tx_buffer;
    tx_buffer_empty_next   = tx_buffer_empty;
    shift_reg_next         = shift_reg;
    rx_buffer_next         = rx_buffer;
    rx_buffer_full_next    = rx_buffer_full;
    overrun_flag_next      = overrun_flag;
    overrun_data_read_next = overrun_data_read;
    bit_count_next         = bit_count;
    prescale_count_next    = prescale_count;
    shifting_next          = shifting;
    mosi_level_next        = mosi_level;
    sck_level_next         = shifting ? sck_level : clock_polarity;
    rd_next                = '0;
    leading                = 1'b0;
    case (mode)
      MODE_TICK: begin
        if (enable) begin
          if (!shifting) begin
            if (!tx_buffer_empty) begin
              shift_reg_next       = tx_buffer & frame_mask;
              tx_buffer_empty_next = 1'b1;
              shifting_next        = 1'b1;
              bit_count_next       = '0;
              prescale_count_next  = '0;
              sck_level_next       = clock_polarity;
              if (!clock_phase) begin
                mosi_level_next = out_bit(tx_buffer & frame_mask, lsb_first, wide_frame);
              end
            end
          end else begin
            prescale_count_next = prescale_inc;
            if ({1'b0, prescale_inc} >= baud_limit) begin
              prescale_count_next = '0;
              sck_level_next      = ~sck_level_next;
              leading             = sck_level_next != clock_polarity;
              if (leading ^ clock_phase) begin
                if (bit_count < frame_len) begin
                  if (lsb_first) begin
                    shift_reg_next = wide_frame ? {miso_in, shift_reg[15:1]}
                                                : {8'h00, miso_in, shift_reg[7:1]};
                  end else begin
                    shift_reg_next = wide_frame ? {shift_reg[14:0], miso_in}
                                                : {8'h00, shift_reg[6:0], miso_in};
                  end
                  bit_count_next = bit_count + CNT_W'(1);
                end
              end else if (bit_count < frame_len) begin
                mosi_level_next = out_bit(shift_reg, lsb_first, wide_frame);
              end
              if (!leading && bit_count_next >= frame_len) begin
                shifting_next = 1'b0;
                if (rx_buffer_full) begin
                  overrun_flag_next = 1'b1;
                end else begin
                  rx_buffer_next      = shift_reg_next & frame_mask;
                  rx_buffer_full_next = 1'b1;
                end
              end
            end
          end
        end
      end
      MODE_STATUS: begin
        rd_next[ST_RXNE_BIT] = rx_buffer_full;
        rd_next[ST_TXE_BIT]  = tx_buffer_empty;
        rd_next[ST_OVR_BIT]  = overrun_flag;
        rd_next[ST_BSY_BIT]  = shifting | ~tx_buffer_empty;
        if (overrun_data_read) begin
          overrun_flag_next = 1'b0;
        end
        overrun_data_read_next = 1'b0;
      end
      MODE_READ: begin
        rd_next             = rx_buffer;
        rx_buffer_full_next = 1'b0;
        if (overrun_flag) begin
          overrun_data_read_next = 1'b1;
        end
      end
      default: begin
        tx_buffer_next       = write_data & frame_mask;
        tx_buffer_empty_next = 1'b0;
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      baud_code      <= '0;
      clock_polarity <= 1'b0;
      clock_phase    <= 1'b0;
      lsb_first      <= 1'b0;
      wide_frame     <= 1'b0;
      enable         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAUD:   baud_code      <= cfg_data[BAUD_W-1:0];
        REG_CPOL:   clock_polarity <= cfg_data[0];
        REG_CPHA:   clock_phase    <= cfg_data[0];
        REG_LSB:    lsb_first      <= cfg_data[0];
        REG_WIDE:   wide_frame     <= cfg_data[0];
        REG_ENABLE: enable         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // state update on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_buffer         <= '0;
      tx_buffer_empty   <= 1'b1;
      shift_reg         <= '0;
      rx_buffer         <= '0;
      rx_buffer_full    <= 1'b0;
      overrun_flag      <= 1'b0;
      overrun_data_read <= 1'b0;
      bit_count         <= '0;
      prescale_count    <= '0;
      sck_level         <= 1'b0;
      shifting          <= 1'b0;
      mosi_level        <= 1'b0;
    end else if (in_accept) begin
      tx_buffer         <= tx_buffer_next;
      tx_buffer_empty   <= tx_buffer_empty_next;
      shift_reg         <= shift_reg_next;
      rx_buffer         <= rx_buffer_next;
      rx_buffer_full    <= rx_buffer_full_next;
      overrun_flag      <= overrun_flag_next;
      overrun_data_read <= overrun_data_read_next;
      bit_count         <= bit_count_next;
      prescale_count    <= prescale_count_next;
      sck_level         <= sck_level_next;
      shifting          <= shifting_next;
      mosi_level        <= mosi_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      read_data <= rd_next;
      sck_out   <= sck_level_next;
      mosi_out  <= mosi_level_next;
      tx_empty  <= tx_buffer_empty_next;
      rx_full   <= rx_buffer_full_next;
      busy_res  <= shifting_next | ~tx_buffer_empty_next;
      overrun   <= overrun_flag_next;
    end
  end

endmodule

// File: rtl/spim_chk.sv
// port-level checks for the spi master controller, bound to the top level
module spim_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input spim_pkg::mode_t                    mode,
  input logic                               out_valid,
  input logic                               out_stall,
  input spim_pkg::data_t                    read_data,
  input logic                               tx_empty,
  input logic                               rx_full,
  input logic                               busy_res
);
  import spim_pkg::*;

  // every accepted beat yields a result beat in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(rx_full))
    else $error("stalled result changed");

  // a data write fills the transmit buffer and marks the block busy
  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_WRITE |=> !tx_empty && busy_res && read_data == '0)
    else $error("data write did not fill the transmit buffer");

  // a data read empties the receive buffer
  a_read_empties: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_READ |=> !rx_full)
    else $error("data read left the receive buffer full");

  // ticks return no read data
  a_tick_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_TICK |=> read_data == '0)
    else $error("tick returned read data");

endmodule

bind spi_master_controller spim_chk u_spim_chk (.*);

// File: verif/testbench.sv
// self-checking testbench for the spi master controller: bus accesses, ticks and register setups
module testbench;
  import spim_pkg::*;

  localparam int WAIT_MAX    = 17;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 38;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    mode_t op;
    data_t wdata;
    logic  miso;
  } spi_access_t;

  typedef struct {
    data_t rdata;
    logic  sck;
    logic  mosi;
    logic  txe;
    logic  rxf;
    logic  busy;
    logic  ovr;
  } pin_state_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  mode_t                 mode = MODE_TICK;
  data_t                 write_data = '0;
  logic                  miso_in = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  data_t                 read_data;
  logic                  sck_out;
  logic                  mosi_out;
  logic                  tx_empty;
  logic                  rx_full;
  logic                  busy_res;
  logic                  overrun;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  spi_master_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .write_data(write_data), .miso_in(miso_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .sck_out(sck_out), .mosi_out(mosi_out),
    .tx_empty(tx_empty), .rx_full(rx_full), .busy_res(busy_res), .overrun(overrun),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow of the controller
  logic [BAUD_W-1:0]  baud_r;
  logic               cpol_r, cpha_r, lsb_r, wide_r, en_r;
  data_t              txbuf, shreg, rxbuf;
  logic               txbuf_empty, rxbuf_full, ovr_flag, ovr_armed;
  logic [CNT_W-1:0]   nbits;
  logic [PRESC_W-1:0] presc;
  logic               sck_lvl, shifting, mosi_lvl;

  spi_access_t access_q[$];
  pin_state_t  pins_q[$];
  spi_access_t on_bus;
  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  bit          no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned frame_bits();
    return wide_r ? 16 : 8;
  endfunction

  function automatic data_t frame_mask();
    return wide_r ? 16'hFFFF : 16'h00FF;
  endfunction

  function automatic logic next_tx_bit();
    return lsb_r ? shreg[0] : shreg[frame_bits() - 1];
  endfunction

  function automatic void clear_model();
    {baud_r, cpol_r, cpha_r, lsb_r, wide_r, en_r} = '0;
    txbuf = '0;
    txbuf_empty = 1'b1;
    shreg = '0;
    rxbuf = '0;
    rxbuf_full = 1'b0;
    ovr_flag = 1'b0;
    ovr_armed = 1'b0;
    nbits = '0;
    presc = '0;
    shifting = 1'b0;
    mosi_lvl = 1'b0;
    sck_lvl = cpol_r;
  endfunction

  function automatic void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
    case (idx)
      REG_BAUD:   baud_r = word[BAUD_W-1:0];
      REG_CPOL:   cpol_r = word[0];
      REG_CPHA:   cpha_r = word[0];
      REG_LSB:    lsb_r = word[0];
      REG_WIDE:   wide_r = word[0];
      REG_ENABLE: en_r = word[0];
      default: ;
    endcase
    if (!shifting) sck_lvl = cpol_r;
  endfunction

  function automatic void shift_in(logic b);
    if (nbits >= frame_bits()) return;
    if (lsb_r) shreg = ((shreg & frame_mask()) >> 1) | (data_t'(b) << (frame_bits() - 1));
    else shreg = ((shreg << 1) | data_t'(b)) & frame_mask();
    nbits = nbits + 1'b1;
  endfunction

  function automatic void advance(logic b);
    logic lead;
    if (!en_r) return;
    if (!shifting) begin
      if (!txbuf_empty) begin
        shreg = txbuf & frame_mask();
        txbuf_empty = 1'b1;
        shifting = 1'b1;
        nbits = '0;
        presc = '0;
        sck_lvl = cpol_r;
        if (!cpha_r) mosi_lvl = next_tx_bit();
      end
      return;
    end
    presc = presc + 1'b1;
    if (int'(presc) < (1 << baud_r)) return;
    presc = '0;
    sck_lvl = ~sck_lvl;
    lead = (sck_lvl != cpol_r);
    if (lead ^ cpha_r) shift_in(b);
    else if (nbits < frame_bits()) mosi_lvl = next_tx_bit();
    if (!lead && nbits >= frame_bits()) begin
      shifting = 1'b0;
      if (rxbuf_full) begin
        ovr_flag = 1'b1;
      end else begin
        rxbuf = shreg & frame_mask();
        rxbuf_full = 1'b1;
      end
    end
  endfunction

  function automatic pin_state_t predict_pins(spi_access_t a);
    pin_state_t r;
    r.rdata = '0;
    if (!shifting) sck_lvl = cpol_r;
    case (a.op)
      MODE_TICK: advance(a.miso);
      MODE_STATUS: begin
        r.rdata[ST_RXNE_BIT] = rxbuf_full;
        r.rdata[ST_TXE_BIT] = txbuf_empty;
        r.rdata[ST_OVR_BIT] = ovr_flag;
        r.rdata[ST_BSY_BIT] = shifting || !txbuf_empty;
        if (ovr_armed) ovr_flag = 1'b0;
        ovr_armed = 1'b0;
      end
      MODE_READ: begin
        r.rdata = rxbuf;
        rxbuf_full = 1'b0;
        if (ovr_flag) ovr_armed = 1'b1;
      end
      default: begin
        txbuf = a.wdata & frame_mask();
        txbuf_empty = 1'b0;
      end
    endcase
    r.sck = sck_lvl;
    r.mosi = mosi_lvl;
    r.txe = txbuf_empty;
    r.rxf = rxbuf_full;
    r.busy = shifting || !txbuf_empty;
    r.ovr = ovr_flag;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    if (no_idle || $urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, WAIT_MAX);
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall) pins_q.push_back(predict_pins(on_bus));
      if (!in_valid || !in_stall) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (access_q.size() != 0) begin
          on_bus = access_q.pop_front();
          mode <= on_bus.op;
          write_data <= on_bus.wdata;
          miso_in <= on_bus.miso;
          in_valid <= 1'b1;
          tx_gap = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pin_state_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pins_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual read_data %0h", $time, read_data);
          mismatches++;
        end else begin
          want = pins_q.pop_front();
          check_field("read_data", want.rdata, read_data);
          check_field("sck_out", want.sck, sck_out);
          check_field("mosi_out", want.mosi, mosi_out);
          check_field("tx_empty", want.txe, tx_empty);
          check_field("rx_full", want.rxf, rx_full);
          check_field("busy_res", want.busy, busy_res);
          check_field("overrun", want.ovr, overrun);
        end
        rx_wait = draw_wait();
      end else if (rx_wait != 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic queue_access(mode_t op, data_t wdata, logic miso);
    spi_access_t a;
    a.op = op;
    a.wdata = wdata;
    a.miso = miso;
    access_q.push_back(a);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BAUD_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = {13'($urandom_range(0, 8191)), value};
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= word;
    do @(posedge clk); while (!cfg_ready);
    set_reg(idx, word);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setup(logic [BAUD_W-1:0] baud, logic cpol, logic cpha, logic lsb,
                             logic wide, logic en);
    write_reg(REG_BAUD, baud);
    write_reg(REG_CPOL, {2'b00, cpol});
    write_reg(REG_CPHA, {2'b00, cpha});
    write_reg(REG_LSB, {2'b00, lsb});
    write_reg(REG_WIDE, {2'b00, wide});
    write_reg(REG_ENABLE, {2'b00, en});
  endtask

  // wait for every beat to come back, then let the result register settle
  task automatic settle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write a frame, tick it (sometimes too few ticks to finish), read it back; sometimes skip the read to force overrun
  task automatic frame_sequence();
    int unsigned need;
    int unsigned n;
    need = (wide_r ? 32 : 16) * (1 << baud_r) + 2;
    if (need > 60) n = $urandom_range(30, 60);
    else if ($urandom_range(0, 4) == 0) n = $urandom_range(0, need);
    else n = need + $urandom_range(0, 3);
    if ($urandom_range(0, 2) == 0) queue_access(MODE_STATUS, data_t'($urandom), 1'($urandom));
    queue_access(MODE_WRITE, data_t'($urandom), 1'($urandom));
    if ($urandom_range(0, 5) == 0) queue_access(MODE_WRITE, data_t'($urandom), 1'($urandom));
    repeat (n) queue_access(MODE_TICK, data_t'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) != 0) queue_access(MODE_READ, data_t'($urandom), 1'($urandom));
    queue_access(MODE_STATUS, data_t'($urandom), 1'($urandom));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        queue_access(mode_t'($urandom_range(0, 3)), data_t'($urandom), 1'($urandom));
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    logic [BAUD_W-1:0] baud;
    logic cpol, cpha, lsb, wide, en;
    clear_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    write_reg(REG_SPARE_LO, 3'b111);
    write_reg(REG_SPARE_HI, 3'b000);
    apply_setup(3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    // read before anything arrived, then a replaced frame shifted through at full rate
    queue_access(MODE_READ, 16'h0000, 1'b0);
    queue_access(MODE_STATUS, 16'hFFFF, 1'b1);
    queue_access(MODE_TICK, 16'h0000, 1'b1);
    queue_access(MODE_WRITE, 16'h0000, 1'b0);
    queue_access(MODE_WRITE, 16'hFFFF, 1'b1);
    for (int i = 0; i < 17; i++) queue_access(MODE_TICK, 16'h5A5A, 1'(i));
    queue_access(MODE_STATUS, 16'h0000, 1'b0);
    queue_access(MODE_READ, 16'hFFFF, 1'b1);
    queue_access(MODE_STATUS, 16'h0000, 1'b0);
    settle();

    for (int p = 0; p < 7; p++) begin
      baud = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 1));
      {cpol, cpha, lsb, wide} = 4'($urandom);
      en = ($urandom_range(0, 5) != 0);
      case (p)
        0: {baud, cpol, cpha, lsb, wide, en} = {3'd7, 5'b11111};
        1: {baud, cpol, cpha, lsb, wide, en} = {3'd0, 5'b10101};
        2: en = 1'b0;
        default: ;
      endcase
      no_idle = (p == 1) || ($urandom_range(0, 4) == 0);
      apply_setup(baud, cpol, cpha, lsb, wide, en);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) begin
        frame_sequence();
        if ($urandom_range(0, 9) == 0) settle();
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spim_pkg.sv
rtl/spi_master_controller.sv
rtl/spim_chk.sv
verif/testbench.sv
